// ----- hw/rtl/wsda_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsda_pkg: shared types for the weighted squared difference accumulator
// Command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package wsda_pkg;

    localparam int QUOT_BITS = 32;
    localparam int FRAC_BITS = 16;

    typedef struct packed {
        logic load;      // capture operands, start the division
        logic step;      // one restoring-division step
        logic finish;    // fold quotient into the sum
        logic emit_clear; // result taken: clear sum and flags
    } wsda_cmd_t;

    typedef struct packed {
        logic zero_div;  // captured product was zero
        logic early_sat; // integer part already too large
        logic last;      // captured item ends the vector
    } wsda_status_t;

endpackage

// ----- hw/rtl/wsda_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsda_ctrl: sequencer for the accumulator
// Accepts an item, runs up to STEPS divider steps (fewer on a zero divisor or early overflow), folds, emits on last.
// ----------------------------------------------------------------------------
module wsda_ctrl
    import wsda_pkg::*;
#(
    parameter int STEPS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  wsda_status_t status,
    output wsda_cmd_t    cmd
);

    localparam int CW = $clog2(STEPS + 1);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_FOLD, S_OUT} state_t;

    state_t        state_reg;
    logic [CW-1:0] count_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    always_comb begin
        cmd            = '0;
        cmd.load       = (state_reg == S_IDLE) && s_valid;
        cmd.step       = (state_reg == S_DIV);
        cmd.finish     = (state_reg == S_FOLD);
        cmd.emit_clear = (state_reg == S_OUT) && m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_DIV;
                        count_reg <= CW'(STEPS - 1);
                    end
                end
                S_DIV: begin
                    if (status.zero_div || status.early_sat || count_reg == '0) begin
                        state_reg <= S_FOLD;
                    end else begin
                        count_reg <= count_reg - 1'b1;
                    end
                end
                S_FOLD: begin
                    state_reg <= status.last ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/wsda_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsda_datapath: squared difference, spread product, serial divider, sum
// Restoring divider produces one quotient bit per step, MSB first.
// ----------------------------------------------------------------------------
module wsda_datapath
    import wsda_pkg::*;
#(
    parameter int SAMPLE_BITS = 32,
    parameter int SUM_BITS    = 48
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  wsda_cmd_t              cmd,
    output wsda_status_t           status,
    input  logic [31:0]            s_mean_a,
    input  logic [31:0]            s_mean_b,
    input  logic [31:0]            s_spread_a,
    input  logic [31:0]            s_spread_b,
    input  logic                   s_last_element,
    output logic [47:0]            m_distance_sum,
    output logic                   m_zero_divisor,
    output logic                   m_saturated
);

    localparam int PW = 2 * SAMPLE_BITS;       // product / square width
    localparam int NW = PW + FRAC_BITS;        // dividend width

    logic [PW-1:0]        den_reg;
    logic [NW-1:0]        num_reg;   // dividend shifts out MSB first
    logic [PW:0]          rem_reg;
    logic [QUOT_BITS-1:0] quot_reg;
    logic                 last_reg;
    logic                 ovf_reg;
    logic [SUM_BITS-1:0]  sum_reg;
    logic                 zflag_reg;
    logic                 sflag_reg;

    logic signed [SAMPLE_BITS:0] diff;
    logic [SAMPLE_BITS:0]        mag;
    logic [PW:0]                 rem_sh;
    logic [PW:0]                 rem_sub;
    logic                        take;
    logic [SUM_BITS:0]           sum_add;

    assign diff = $signed({s_mean_a[SAMPLE_BITS-1], s_mean_a[SAMPLE_BITS-1:0]})
                - $signed({s_mean_b[SAMPLE_BITS-1], s_mean_b[SAMPLE_BITS-1:0]});
    assign mag  = diff[SAMPLE_BITS] ? SAMPLE_BITS'(0) - diff : diff;

    assign rem_sh  = {rem_reg[PW-1:0], num_reg[NW-1]};
    assign take    = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    assign status.zero_div  = (den_reg == '0);
    // a quotient bit above bit 31 means the result cannot fit
    assign status.early_sat = ovf_reg;
    assign status.last      = last_reg;

    assign sum_add = {1'b0, sum_reg} + (SUM_BITS + 1)'(ovf_reg ? {QUOT_BITS{1'b1}} : quot_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            den_reg  <= PW'(s_spread_a[SAMPLE_BITS-1:0]) * PW'(s_spread_b[SAMPLE_BITS-1:0]);
            // |diff| never exceeds 2^SAMPLE_BITS - 1, so the top bit of mag is zero
            num_reg  <= {PW'(mag[SAMPLE_BITS-1:0]) * PW'(mag[SAMPLE_BITS-1:0]),
                         {FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            quot_reg <= '0;
            ovf_reg  <= 1'b0;
            last_reg <= s_last_element;
        end else if (cmd.step) begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            rem_reg <= take ? rem_sub : rem_sh;
            quot_reg <= {quot_reg[QUOT_BITS-2:0], take};
            // leading bits feed only the overflow detect
            if (quot_reg[QUOT_BITS-1]) begin
                ovf_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            zflag_reg <= 1'b0;
            sflag_reg <= 1'b0;
        end else if (cmd.emit_clear) begin
            sum_reg   <= '0;
            zflag_reg <= 1'b0;
            sflag_reg <= 1'b0;
        end else if (cmd.finish) begin
            if (status.zero_div) begin
                zflag_reg <= 1'b1;
            end else begin
                if (ovf_reg) begin
                    sflag_reg <= 1'b1;
                end
                if (sum_add[SUM_BITS]) begin
                    sum_reg   <= '1;
                    sflag_reg <= 1'b1;
                end else begin
                    sum_reg <= sum_add[SUM_BITS-1:0];
                end
            end
        end
    end

    assign m_distance_sum = 48'(sum_reg);
    assign m_zero_divisor = zflag_reg;
    assign m_saturated    = sflag_reg;

endmodule

// ----- hw/rtl/weighted_sq_diff_accumulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_sq_diff_accumulator: variance-weighted squared distance
// Sums (mean_a-mean_b)^2/(spread_a*spread_b) per vector, emits on last item.
// ----------------------------------------------------------------------------
// m_valid rises once the last item taken has run through the division (one
// restoring-division step per cycle) and then the fold state. A new item is
// taken only after the previous one is folded; a last item also waits for m_ready.
// A zero spread product ends the division after its first step; an oversized
// quotient ends it early, once the overflow has been registered.
// Reset (aresetn low, synchronous) clears sum, flags and the sequencer.
module weighted_sq_diff_accumulator
    import wsda_pkg::*;
#(
    parameter int SAMPLE_BITS = 32,
    parameter int SUM_BITS    = 48
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_mean_a,
    input  logic [31:0] s_mean_b,
    input  logic [31:0] s_spread_a,
    input  logic [31:0] s_spread_b,
    input  logic        s_last_element,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [47:0] m_distance_sum,
    output logic        m_zero_divisor,
    output logic        m_saturated
);

    wsda_cmd_t    cmd;
    wsda_status_t status;

    wsda_ctrl #(
        .STEPS(2 * SAMPLE_BITS + FRAC_BITS)
    ) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .status(status), .cmd(cmd)
    );

    wsda_datapath #(
        .SAMPLE_BITS(SAMPLE_BITS), .SUM_BITS(SUM_BITS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .s_mean_a(s_mean_a), .s_mean_b(s_mean_b),
        .s_spread_a(s_spread_a), .s_spread_b(s_spread_b),
        .s_last_element(s_last_element),
        .m_distance_sum(m_distance_sum), .m_zero_divisor(m_zero_divisor),
        .m_saturated(m_saturated)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input open while result pending");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance_sum))
        else $error("result changed while stalled");

    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_zero_divisor && !m_saturated)
        else $error("flags not cleared after result");

endmodule
